### src/lta_pkg.sv
// ----------------------------------------------------------------------------
// lta_pkg
// Shared types and constants for the prefix-match traffic accounting block.
// ----------------------------------------------------------------------------
package lta_pkg;

  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] ST_COUNTED   = 3'd0;
  localparam logic [2:0] ST_NOT_IPV4  = 3'd1;
  localparam logic [2:0] ST_SHORT     = 3'd2;
  localparam logic [2:0] ST_NO_MATCH  = 3'd3;
  localparam logic [2:0] ST_WRITTEN   = 3'd4;
  localparam logic [2:0] ST_READ      = 3'd5;

  localparam logic [15:0] ETHER_IPV4  = 16'h0800;
  localparam logic [15:0] MIN_LEN_OUT = 16'd34;
  localparam logic [15:0] MIN_LEN_IN  = 16'd30;
  localparam logic [5:0]  ADDR_BITS   = 6'd32;

  localparam int CNT_W = 64;

  typedef struct packed {
    logic capture;
    logic clr;
    logic scan_step;
    logic tbl_wr;
    logic cnt_rd;
    logic cnt_upd;
    logic load_out;
  } lta_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       pkt_ok;
    logic       in_table;
    logic       idx_last;
    logic       found;
    logic       out_free;
  } lta_sts_t;

endpackage

### src/lta_ctrl.sv
// ----------------------------------------------------------------------------
// lta_ctrl
// Sequencer: clearing pass, table scan, counter update and result hand-off.
// ----------------------------------------------------------------------------
module lta_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lta_pkg::lta_sts_t sts,
  output lta_pkg::lta_cmd_t cmd
);
  import lta_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_TAIL  = 3'd4;
  localparam logic [2:0] S_CRD   = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.idx_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.opcode)
          OP_WRITE: begin
            cmd.tbl_wr = sts.in_table;
            state_nxt  = S_DONE;
          end
          OP_READ:   state_nxt = S_CRD;
          OP_PACKET: state_nxt = sts.pkt_ok ? S_SCAN : S_DONE;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.idx_last) state_nxt = S_TAIL;
      end
      // last compare lands here
      S_TAIL: state_nxt = S_CRD;
      S_CRD: begin
        if ((sts.opcode == OP_READ) ? sts.in_table : sts.found) begin
          cmd.cnt_rd = 1'b1;
          state_nxt  = S_UPD;
        end else begin
          state_nxt  = S_DONE;
        end
      end
      S_UPD: begin
        cmd.cnt_upd = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

### src/lta_dp.sv
// ----------------------------------------------------------------------------
// lta_dp
// Datapath: request registers, prefix table, counter memory, result register.
// ----------------------------------------------------------------------------
module lta_dp #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lta_pkg::lta_cmd_t cmd,
  output lta_pkg::lta_sts_t sts,
  input  logic [1:0]        in_opcode,
  input  logic [15:0]       in_ether_type,
  input  logic              in_outgoing,
  input  logic [31:0]       in_src_addr,
  input  logic [31:0]       in_dst_addr,
  input  logic [15:0]       in_packet_length,
  input  logic [7:0]        in_entry_index,
  input  logic [31:0]       in_entry_prefix,
  input  logic [5:0]        in_entry_prefix_len,
  input  logic              in_entry_valid,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [7:0]        out_match_index,
  output logic [63:0]       out_tx_bytes,
  output logic [63:0]       out_tx_packets,
  output logic [63:0]       out_rx_bytes,
  output logic [63:0]       out_rx_packets
);
  import lta_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int TBL_W = 1 + 6 + 32;
  localparam int ROW_W = 4 * CNT_W;

  logic [1:0]  opcode_r;
  logic [15:0] ether_r;
  logic        outg_r;
  logic [31:0] src_r, dst_r;
  logic [15:0] len_r;
  logic [7:0]  eidx_r;
  logic [31:0] epfx_r;
  logic [5:0]  eplen_r;
  logic        evld_r;

  logic [IDX_W-1:0] idx_r, cmp_idx_r, best_r;
  logic             cmp_vld_r, found_r;
  logic [5:0]       best_len_r;

  logic [TBL_W-1:0] tbl_mem [TABLE_ENTRIES];
  logic [TBL_W-1:0] tbl_rd_r;
  logic [ROW_W-1:0] cnt_mem [TABLE_ENTRIES];
  logic [ROW_W-1:0] cnt_rd_r, upd_r, cnt_new;

  logic             out_valid_r;
  logic [2:0]       status_r;
  logic [7:0]       mindex_r;
  logic [ROW_W-1:0] ocnt_r;

  logic [IDX_W-1:0] eaddr, cnt_raddr;
  logic             in_table, idx_last, pkt_ok, hit;
  logic [5:0]       sat_len, rd_len;
  logic [31:0]      key, mask;
  logic [63:0]      add_len;

  assign eaddr     = IDX_W'(eidx_r);
  assign in_table  = 32'(eidx_r) < 32'(TABLE_ENTRIES);
  assign idx_last  = idx_r == IDX_W'(TABLE_ENTRIES - 1);
  assign pkt_ok    = (ether_r == ETHER_IPV4) &&
                     (len_r >= (outg_r ? MIN_LEN_OUT : MIN_LEN_IN));
  assign sat_len   = (eplen_r > ADDR_BITS) ? ADDR_BITS : eplen_r;
  assign key       = outg_r ? dst_r : src_r;
  assign rd_len    = tbl_rd_r[37:32];
  assign mask      = ~(32'hFFFF_FFFF >> rd_len);
  assign hit       = tbl_rd_r[38] && (((key ^ tbl_rd_r[31:0]) & mask) == 32'd0);
  assign cnt_raddr = (opcode_r == OP_READ) ? eaddr : best_r;
  assign add_len   = {48'd0, len_r};

  assign sts.opcode   = opcode_r;
  assign sts.pkt_ok   = pkt_ok;
  assign sts.in_table = in_table;
  assign sts.idx_last = idx_last;
  assign sts.found    = found_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      opcode_r <= in_opcode;
      ether_r  <= in_ether_type;
      outg_r   <= in_outgoing;
      src_r    <= in_src_addr;
      dst_r    <= in_dst_addr;
      len_r    <= in_packet_length;
      eidx_r   <= in_entry_index;
      epfx_r   <= in_entry_prefix;
      eplen_r  <= in_entry_prefix_len;
      evld_r   <= in_entry_valid;
    end
  end

  // shared sweep index for the clearing pass and the table scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      if (cmd.clr || cmd.scan_step) idx_r <= idx_last ? '0 : idx_r + 1'b1;
      cmp_vld_r <= cmd.scan_step;
      if (cmd.capture) begin
        found_r <= 1'b0;
      end else if (cmp_vld_r && hit && (!found_r || rd_len > best_len_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r;
    if (cmp_vld_r && hit && (!found_r || rd_len > best_len_r)) begin
      best_r     <= cmp_idx_r;
      best_len_r <= rd_len;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr)         tbl_mem[idx_r] <= '0;
    else if (cmd.tbl_wr) tbl_mem[eaddr] <= {evld_r, sat_len, epfx_r};
    if (cmd.scan_step)   tbl_rd_r <= tbl_mem[idx_r];
  end

  always_comb begin
    cnt_new = cnt_rd_r;
    if (outg_r) begin
      cnt_new[4*CNT_W-1:3*CNT_W] = cnt_rd_r[4*CNT_W-1:3*CNT_W] + add_len;
      cnt_new[3*CNT_W-1:2*CNT_W] = cnt_rd_r[3*CNT_W-1:2*CNT_W] + 64'd1;
    end else begin
      cnt_new[2*CNT_W-1:CNT_W]   = cnt_rd_r[2*CNT_W-1:CNT_W] + add_len;
      cnt_new[CNT_W-1:0]         = cnt_rd_r[CNT_W-1:0] + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr)         cnt_mem[idx_r] <= '0;
    else if (cmd.tbl_wr) cnt_mem[eaddr] <= '0;
    else if (cmd.cnt_upd && opcode_r == OP_PACKET) cnt_mem[best_r] <= cnt_new;
    if (cmd.cnt_rd)      cnt_rd_r <= cnt_mem[cnt_raddr];
    if (cmd.cnt_upd)     upd_r <= (opcode_r == OP_PACKET) ? cnt_new : cnt_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      priority if (opcode_r == OP_WRITE) begin
        status_r <= ST_WRITTEN;
        mindex_r <= eidx_r;
        ocnt_r   <= '0;
      end else if (opcode_r == OP_READ) begin
        status_r <= ST_READ;
        mindex_r <= eidx_r;
        ocnt_r   <= in_table ? upd_r : '0;
      end else if (ether_r != ETHER_IPV4) begin
        status_r <= ST_NOT_IPV4;
        mindex_r <= '0;
        ocnt_r   <= '0;
      end else if (!pkt_ok) begin
        status_r <= ST_SHORT;
        mindex_r <= '0;
        ocnt_r   <= '0;
      end else if (!found_r) begin
        status_r <= ST_NO_MATCH;
        mindex_r <= '0;
        ocnt_r   <= '0;
      end else begin
        status_r <= ST_COUNTED;
        mindex_r <= 8'(best_r);
        ocnt_r   <= upd_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_match_index = mindex_r;
  assign out_tx_bytes    = ocnt_r[4*CNT_W-1:3*CNT_W];
  assign out_tx_packets  = ocnt_r[3*CNT_W-1:2*CNT_W];
  assign out_rx_bytes    = ocnt_r[2*CNT_W-1:CNT_W];
  assign out_rx_packets  = ocnt_r[CNT_W-1:0];

endmodule

### src/lpm_traffic_accounting_top.sv
// One request in flight; the next is accepted in the cycle after the result is loaded.
// An unused opcode returns to idle without loading a result.
// The result load waits while an earlier result is stalled in the output register.
// Synchronous reset, then a clearing pass over every entry zeroes both tables.
// ----------------------------------------------------------------------------
// lpm_traffic_accounting_top
// Per-subnet IPv4 traffic accounting with longest prefix match.
// ----------------------------------------------------------------------------
module lpm_traffic_accounting_top #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_ether_type,
  input  logic        in_outgoing,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_packet_length,
  input  logic [7:0]  in_entry_index,
  input  logic [31:0] in_entry_prefix,
  input  logic [5:0]  in_entry_prefix_len,
  input  logic        in_entry_valid,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_match_index,
  output logic [63:0] out_tx_bytes,
  output logic [63:0] out_tx_packets,
  output logic [63:0] out_rx_bytes,
  output logic [63:0] out_rx_packets
);
  import lta_pkg::*;

  lta_cmd_t cmd;
  lta_sts_t sts;

  lta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lta_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_opcode           (in_opcode),
    .in_ether_type       (in_ether_type),
    .in_outgoing         (in_outgoing),
    .in_src_addr         (in_src_addr),
    .in_dst_addr         (in_dst_addr),
    .in_packet_length    (in_packet_length),
    .in_entry_index      (in_entry_index),
    .in_entry_prefix     (in_entry_prefix),
    .in_entry_prefix_len (in_entry_prefix_len),
    .in_entry_valid      (in_entry_valid),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_match_index     (out_match_index),
    .out_tx_bytes        (out_tx_bytes),
    .out_tx_packets      (out_tx_packets),
    .out_rx_bytes        (out_rx_bytes),
    .out_rx_packets      (out_rx_packets)
  );

  // at most one of clear, table write, counter update or scan step per cycle
  a_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr, cmd.tbl_wr, cmd.cnt_upd, cmd.scan_step}))
    else $error("conflicting memory commands");

  // a result never overwrites one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result register overwritten");

  // one request in flight
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request accepted while busy");

endmodule

### dv/lpm_traffic_accounting_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_traffic_accounting_checker
// Watches both channels of the accounting block, keeps its own copy of the
// prefix table and counters, and compares each result with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module lpm_traffic_accounting_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_ether_type,
  input  logic        in_outgoing,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_packet_length,
  input  logic [7:0]  in_entry_index,
  input  logic [31:0] in_entry_prefix,
  input  logic [5:0]  in_entry_prefix_len,
  input  logic        in_entry_valid,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [7:0]  out_match_index,
  input  logic [63:0] out_tx_bytes,
  input  logic [63:0] out_tx_packets,
  input  logic [63:0] out_rx_bytes,
  input  logic [63:0] out_rx_packets,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  import lta_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  index;
    logic [63:0] tx_bytes;
    logic [63:0] tx_packets;
    logic [63:0] rx_bytes;
    logic [63:0] rx_packets;
  } acct_result_t;

  logic        tbl_valid [256];
  logic [31:0] tbl_prefix [256];
  logic [5:0]  tbl_len [256];
  logic [63:0] sent_bytes [256];
  logic [63:0] sent_pkts [256];
  logic [63:0] recv_bytes [256];
  logic [63:0] recv_pkts [256];

  acct_result_t expected_q[$];

  initial begin
    for (int i = 0; i < 256; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_prefix[i] = '0;
      tbl_len[i] = '0;
      sent_bytes[i] = '0;
      sent_pkts[i] = '0;
      recv_bytes[i] = '0;
      recv_pkts[i] = '0;
    end
    fail_count = 0;
    result_count = 0;
    pending_count = 0;
  end

  function automatic logic [31:0] len_mask(logic [5:0] len);
    if (len == 0) return 32'h0;
    return 32'hffff_ffff << (6'd32 - len);
  endfunction

  function automatic acct_result_t counters_of(logic [2:0] st, logic [7:0] idx);
    acct_result_t r;
    r.status = st;
    r.index = idx;
    r.tx_bytes = sent_bytes[idx];
    r.tx_packets = sent_pkts[idx];
    r.rx_bytes = recv_bytes[idx];
    r.rx_packets = recv_pkts[idx];
    return r;
  endfunction

  task automatic account_request();
    acct_result_t r;
    logic [31:0] key;
    logic        found;
    logic [7:0]  best;
    logic [5:0]  best_len;
    logic [7:0]  idx;
    r = '0;
    idx = in_entry_index;
    case (in_opcode)
      OP_NONE: return;
      OP_WRITE: begin
        tbl_valid[idx] = in_entry_valid;
        tbl_prefix[idx] = in_entry_prefix;
        tbl_len[idx] = (in_entry_prefix_len > ADDR_BITS) ? ADDR_BITS : in_entry_prefix_len;
        sent_bytes[idx] = '0;
        sent_pkts[idx] = '0;
        recv_bytes[idx] = '0;
        recv_pkts[idx] = '0;
        r = counters_of(ST_WRITTEN, idx);
      end
      OP_READ: r = counters_of(ST_READ, idx);
      default: begin
        if (in_ether_type != ETHER_IPV4) begin
          r.status = ST_NOT_IPV4;
        end else if (in_packet_length < (in_outgoing ? MIN_LEN_OUT : MIN_LEN_IN)) begin
          r.status = ST_SHORT;
        end else begin
          key = in_outgoing ? in_dst_addr : in_src_addr;
          found = 1'b0;
          best = '0;
          best_len = '0;
          for (int i = 0; i < 256; i++) begin
            if (tbl_valid[i] && ((key ^ tbl_prefix[i]) & len_mask(tbl_len[i])) == 0 &&
                (!found || tbl_len[i] > best_len)) begin
              found = 1'b1;
              best = i[7:0];
              best_len = tbl_len[i];
            end
          end
          if (!found) begin
            r.status = ST_NO_MATCH;
          end else begin
            if (in_outgoing) begin
              sent_bytes[best] = sent_bytes[best] + 64'(in_packet_length);
              sent_pkts[best] = sent_pkts[best] + 64'd1;
            end else begin
              recv_bytes[best] = recv_bytes[best] + 64'(in_packet_length);
              recv_pkts[best] = recv_pkts[best] + 64'd1;
            end
            r = counters_of(ST_COUNTED, best);
          end
        end
      end
    endcase
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    acct_result_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_q.size() == 0) begin
          $error("result with no request waiting: status %0d", out_status);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_status);
            fail_count++;
          end
          if (out_match_index !== exp_r.index) begin
            $error("match_index: expected %0d, got %0d", exp_r.index, out_match_index);
            fail_count++;
          end
          if (out_tx_bytes !== exp_r.tx_bytes) begin
            $error("tx_bytes: expected %0d, got %0d", exp_r.tx_bytes, out_tx_bytes);
            fail_count++;
          end
          if (out_tx_packets !== exp_r.tx_packets) begin
            $error("tx_packets: expected %0d, got %0d", exp_r.tx_packets, out_tx_packets);
            fail_count++;
          end
          if (out_rx_bytes !== exp_r.rx_bytes) begin
            $error("rx_bytes: expected %0d, got %0d", exp_r.rx_bytes, out_rx_bytes);
            fail_count++;
          end
          if (out_rx_packets !== exp_r.rx_packets) begin
            $error("rx_packets: expected %0d, got %0d", exp_r.rx_packets, out_rx_packets);
            fail_count++;
          end
        end
      end
      // request is predicted after the compare so a same-cycle result sees old state
      if (in_valid && !in_stall) account_request();
    end
    pending_count = expected_q.size();
  end

endmodule

### dv/lpm_traffic_accounting_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_traffic_accounting_top_test
// Drives table writes, counter reads and IPv4 packets into the accounting
// block with random gaps and output stalls; the checker predicts each result.
// ----------------------------------------------------------------------------
module lpm_traffic_accounting_top_test;
  import lta_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int RANDOM_REQUESTS = 1900;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = OP_NONE;
  logic [15:0] in_ether_type = '0;
  logic        in_outgoing = 1'b0;
  logic [31:0] in_src_addr = '0;
  logic [31:0] in_dst_addr = '0;
  logic [15:0] in_packet_length = '0;
  logic [7:0]  in_entry_index = '0;
  logic [31:0] in_entry_prefix = '0;
  logic [5:0]  in_entry_prefix_len = '0;
  logic        in_entry_valid = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_match_index;
  logic [63:0] out_tx_bytes;
  logic [63:0] out_tx_packets;
  logic [63:0] out_rx_bytes;
  logic [63:0] out_rx_packets;

  int fail_count;
  int pending_count;
  int result_count;
  int cycles = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;
  int n_packets = 0;
  int n_writes = 0;
  int n_reads = 0;
  int n_ignored = 0;

  // prefixes installed so far, used to aim packet addresses at the table
  logic [31:0] known_prefix[$];

  always #1 clk = ~clk;

  lpm_traffic_accounting_top u_top (.*);

  lpm_traffic_accounting_checker u_checker (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // output stall: a random hold after each taken result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      stall_left <= no_idle ? 0 : int'($urandom_range(0, 5));
    else if (out_stall && stall_left > 0)
      stall_left <= stall_left - 1;
  end

  always @(negedge clk) out_stall <= (stall_left > 0);

  task automatic send(logic [1:0] op, logic [15:0] et, logic outg, logic [31:0] src,
                      logic [31:0] dst, logic [15:0] len, logic [7:0] idx,
                      logic [31:0] pfx, logic [5:0] plen, logic ev);
    int gap;
    gap = no_idle ? 0 : int'($urandom_range(0, 5));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode <= op;
    in_ether_type <= et;
    in_outgoing <= outg;
    in_src_addr <= src;
    in_dst_addr <= dst;
    in_packet_length <= len;
    in_entry_index <= idx;
    in_entry_prefix <= pfx;
    in_entry_prefix_len <= plen;
    in_entry_valid <= ev;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    case (op)
      OP_PACKET: n_packets++;
      OP_WRITE: n_writes++;
      OP_READ: n_reads++;
      default: n_ignored++;
    endcase
  endtask

  task automatic ip_packet(logic outg, logic [31:0] addr, logic [15:0] len);
    logic [31:0] other;
    other = $urandom;
    send(OP_PACKET, ETHER_IPV4, outg, outg ? other : addr, outg ? addr : other, len,
         8'($urandom), $urandom, 6'($urandom), 1'($urandom));
  endtask

  task automatic write_entry(logic [7:0] idx, logic [31:0] pfx, logic [5:0] plen, logic ev);
    send(OP_WRITE, 16'($urandom), 1'($urandom), $urandom, $urandom, 16'($urandom), idx, pfx,
         plen, ev);
    if (ev) known_prefix.push_back(pfx);
  endtask

  task automatic read_entry(logic [7:0] idx);
    send(OP_READ, 16'($urandom), 1'($urandom), $urandom, $urandom, 16'($urandom), idx,
         $urandom, 6'($urandom), 1'($urandom));
  endtask

  task automatic random_request();
    int pick;
    logic [31:0] addr;
    logic [5:0] plen;
    logic outg;
    logic [15:0] len;
    pick = $urandom_range(0, 99);
    outg = 1'($urandom);
    if (pick < 14) begin
      plen = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63)) :
                                           6'($urandom_range(0, 32));
      write_entry(8'($urandom), $urandom, plen, $urandom_range(0, 7) != 0);
    end else if (pick < 24) begin
      read_entry(8'($urandom));
    end else if (pick < 27) begin
      send(OP_NONE, 16'($urandom), 1'($urandom), $urandom, $urandom, 16'($urandom),
           8'($urandom), $urandom, 6'($urandom), 1'($urandom));
    end else if (pick < 33) begin
      // noise: any ether type and length
      send(OP_PACKET, ($urandom_range(0, 1) ? ETHER_IPV4 : 16'($urandom)), outg, $urandom,
           $urandom, 16'($urandom), 8'($urandom), $urandom, 6'($urandom), 1'($urandom));
    end else begin
      addr = $urandom;
      if (known_prefix.size() > 0 && $urandom_range(0, 5) != 0) begin
        // keep the prefix bits and randomize a short host part
        addr = known_prefix[$urandom_range(0, known_prefix.size() - 1)];
        addr = addr ^ ($urandom >> $urandom_range(8, 31));
      end
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(26, 38)) :
                                          16'($urandom_range(34, 65535));
      ip_packet(outg, addr, len);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, filters and thresholds, then table writes, matches and reads
    ip_packet(1'b1, 32'h0a00_0001, 16'd1500);
    send(OP_PACKET, 16'hffff, 1'b1, '1, '1, '1, '1, '1, '1, 1'b1);
    send(OP_PACKET, 16'h0000, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0);
    ip_packet(1'b1, 32'h0a00_0001, 16'd33);
    ip_packet(1'b0, 32'h0a00_0001, 16'd29);
    write_entry(8'd0, 32'h1234_5678, 6'd0, 1'b1);
    ip_packet(1'b1, 32'hffff_ffff, 16'd34);
    ip_packet(1'b0, 32'h0000_0000, 16'd30);
    write_entry(8'd1, 32'h0a00_0000, 6'd8, 1'b1);
    write_entry(8'd2, 32'h0aff_0000, 6'd8, 1'b1);
    write_entry(8'd3, 32'h0a01_0000, 6'd16, 1'b1);
    write_entry(8'd255, 32'hc0a8_0101, 6'd63, 1'b1);
    ip_packet(1'b1, 32'h0a02_0304, 16'd65535);
    ip_packet(1'b0, 32'h0a01_0203, 16'd100);
    ip_packet(1'b1, 32'hc0a8_0101, 16'd64);
    ip_packet(1'b1, 32'hc0a8_0100, 16'd64);
    send(OP_NONE, '1, 1'b1, '1, '1, '1, 8'd1, '1, '1, 1'b1);
    read_entry(8'd1);
    read_entry(8'd255);
    write_entry(8'd0, 32'h0, 6'd0, 1'b0);
    read_entry(8'd0);
    ip_packet(1'b1, 32'h7f00_0001, 16'd40);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (i == RANDOM_REQUESTS / 2) begin
        in_valid <= 1'b0;
        wait (pending_count == 0);
        @(negedge clk);
      end
      random_request();
    end
    in_valid <= 1'b0;
    wait (pending_count == 0);
    repeat (300) @(posedge clk);

    $display("covered %0d packets, %0d table writes, %0d reads, %0d ignored requests",
             n_packets, n_writes, n_reads, n_ignored);
    $display("checked %0d results in %0d cycles", result_count, cycles);
    if (fail_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
